### sv/cspe_pkg.sv
package cspe_pkg;

    // table geometry
    localparam int MAX_VERTICES = 1024;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int ELEM_W       = 10;
    localparam int CNT_W        = 11;
    localparam int SUM_W        = CNT_W + 1;

    localparam logic [CNT_W-1:0] ACTIVE_RST = CNT_W'(1024);
    localparam logic [CNT_W-1:0] MAX_CNT    = CNT_W'(MAX_VERTICES);

    typedef enum logic [2:0] {
        K_INIT     = 3'd0,
        K_ISECT    = 3'd1,
        K_EXCL     = 3'd2,
        K_EXCL_ONE = 3'd3,
        K_LOAD     = 3'd4,
        K_QUERY    = 3'd5,
        K_MEMBER   = 3'd6,
        K_NOP      = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POS,
        S_ELEM,
        S_WR2,
        S_MEM,
        S_INIT,
        S_FIN
    } t_state;

endpackage

### sv/cspe_ram.sv
module cspe_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/candidate_set_partition_engine_core.sv
// Candidate set partition engine: a vertex permutation (element by position)
// and its inverse (position by element) held in two 1024 x 10 RAMs, plus a
// candidate window (start, size) and a running count for neighbour runs.
//
// Request channel: start/busy. A request is taken on a clock edge with start
// high and busy low; its fields sit on the i_ ports at that edge.
// Result channel: o_strobe is high for exactly one cycle per request and the
// o_ result ports are valid in that cycle. The receiver cannot stall.
// Config channel: i_cfg_valid/o_cfg_ready writes active_count; ready is
// always high, writes are expected only while idle.
//
// Sequencer steps per request (one RAM read port and one write port per
// table set these): load window / no-op go straight to finish; query / read
// member add one read step; neighbour or exclude-one with a swap read the
// position, read the element, then write twice; init writes one identity
// entry per cycle for n = min(active_count, 1024) entries, then finishes.
// A new request may be taken in the strobe cycle.
// Reset (synchronous, active low) clears the window, the run state and the
// sequencer and sets active_count to 1024; table contents stay undefined
// until an init request fills them.
module candidate_set_partition_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_kind,
    input  logic [9:0]  i_element,
    input  logic        i_last_in_run,
    input  logic [9:0]  i_member_index,
    input  logic [10:0] i_window_start_in,
    input  logic [10:0] i_window_size_in,
    // result channel
    output logic        o_strobe,
    output logic        o_in_window,
    output logic [9:0]  o_position,
    output logic [9:0]  o_member_out,
    output logic        o_member_valid,
    output logic [10:0] o_run_count,
    output logic [10:0] o_window_size_out,
    output logic        o_clipped,
    // config channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data
);

    localparam int AW = cspe_pkg::ADDR_W;
    localparam int EW = cspe_pkg::ELEM_W;
    localparam int CW = cspe_pkg::CNT_W;
    localparam int SW = cspe_pkg::SUM_W;

    cspe_pkg::t_state r_state, n_state;

    // latched request
    cspe_pkg::t_kind  r_kind;
    logic [EW-1:0]    r_elem;
    logic             r_last;
    logic [CW-1:0]    r_ws_in;
    logic [CW-1:0]    r_wz_in;

    // architectural state
    logic [CW-1:0]    r_active;
    logic [CW-1:0]    r_ws;
    logic [CW-1:0]    r_wsz;
    logic [CW-1:0]    r_rc;
    logic             r_run_open;

    // per-request working registers
    logic             r_eok;
    logic [EW-1:0]    r_pb;
    logic [AW-1:0]    r_pa;
    logic [EW-1:0]    r_ea;
    logic             r_mem_ok;
    logic [CW-1:0]    r_idx;

    // result registers
    logic             r_strobe;
    logic             r_inside;
    logic [EW-1:0]    r_pos_out;
    logic [EW-1:0]    r_mem_out;
    logic             r_mval;
    logic             r_clip;
    logic [CW-1:0]    r_out_rc;
    logic [CW-1:0]    r_out_wsz;

    // RAM ports
    logic             elem_we, pos_we;
    logic [AW-1:0]    elem_waddr, pos_waddr, elem_raddr, pos_raddr;
    logic [EW-1:0]    elem_wdata, pos_wdata, elem_rdata, pos_rdata;

    // combinational datapath
    logic [CW-1:0]    w_n;
    logic             w_accept;
    logic             w_eok_in;
    logic [SW-1:0]    w_win_end;
    logic             w_inside;
    logic [CW-1:0]    w_rc0;
    logic             w_do;
    logic [SW-1:0]    w_pa_sum;
    logic             w_swap;
    logic             w_mval_in;
    logic [SW-1:0]    w_mpos;
    logic             w_init_last;
    logic [CW-1:0]    w_ld_ws, w_ld_wz, w_ld_room;
    logic             w_ld_clip;
    logic             w_commit;
    logic [CW-1:0]    w_fin_wsz, w_fin_rc;

    cspe_ram #(.WIDTH(EW), .DEPTH(cspe_pkg::MAX_VERTICES)) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (elem_we),
        .i_waddr (elem_waddr),
        .i_wdata (elem_wdata),
        .i_raddr (elem_raddr),
        .o_rdata (elem_rdata)
    );

    cspe_ram #(.WIDTH(EW), .DEPTH(cspe_pkg::MAX_VERTICES)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    // effective vertex count n = min(active_count, MAX_VERTICES)
    assign w_n      = (int'(r_active) < cspe_pkg::MAX_VERTICES) ? r_active : cspe_pkg::MAX_CNT;
    assign w_accept = start && !busy;
    assign w_eok_in = CW'(i_element) < w_n;

    // window test on the position read back from the position table
    assign w_win_end = SW'(r_ws) + SW'(r_wsz);
    assign w_inside  = r_eok && (SW'(pos_rdata) >= SW'(r_ws)) && (SW'(pos_rdata) < w_win_end);

    // first item of a run seeds the count
    assign w_rc0 = r_run_open ? r_rc :
                   ((r_kind == cspe_pkg::K_ISECT) ? '0 : r_wsz);

    // swap target: front slot for intersect, back slot for exclude
    always_comb begin
        w_do     = 1'b0;
        w_pa_sum = '0;
        case (r_kind)
            cspe_pkg::K_ISECT: begin
                w_do     = w_inside && (w_rc0 < r_wsz);
                w_pa_sum = SW'(r_ws) + SW'(w_rc0);
            end
            cspe_pkg::K_EXCL: begin
                w_do     = w_inside && (w_rc0 != '0);
                w_pa_sum = SW'(r_ws) + SW'(w_rc0) - SW'(1);
            end
            cspe_pkg::K_EXCL_ONE: begin
                w_do     = w_inside && (r_wsz != '0);
                w_pa_sum = SW'(r_ws) + SW'(r_wsz) - SW'(1);
            end
            default: begin
                w_do     = 1'b0;
                w_pa_sum = '0;
            end
        endcase
    end
    assign w_swap = w_do && (int'(w_pa_sum) < cspe_pkg::MAX_VERTICES);

    // read member addressing
    assign w_mval_in = CW'(i_member_index) < r_wsz;
    assign w_mpos    = SW'(r_ws) + SW'(i_member_index);

    assign w_init_last = (r_idx == (w_n - CW'(1)));

    // load window clipping: start saturates at n, size at n - start
    always_comb begin
        w_ld_ws   = (r_ws_in > w_n) ? w_n : r_ws_in;
        w_ld_room = w_n - w_ld_ws;
        w_ld_wz   = (r_wz_in > w_ld_room) ? w_ld_room : r_wz_in;
        w_ld_clip = (r_ws_in > w_n) || (r_wz_in > w_ld_room);
    end

    // end-of-request window size and count as shown on the result
    assign w_commit = ((r_kind == cspe_pkg::K_ISECT) || (r_kind == cspe_pkg::K_EXCL)) && r_last;
    always_comb begin
        w_fin_wsz = r_wsz;
        w_fin_rc  = r_rc;
        case (r_kind)
            cspe_pkg::K_INIT: begin
                w_fin_wsz = w_n;
                w_fin_rc  = '0;
            end
            cspe_pkg::K_LOAD: begin
                w_fin_wsz = w_ld_wz;
                w_fin_rc  = '0;
            end
            default: begin
                w_fin_wsz = w_commit ? r_rc : r_wsz;
                w_fin_rc  = r_rc;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cspe_pkg::S_IDLE: begin
                if (start) begin
                    case (cspe_pkg::t_kind'(i_kind))
                        cspe_pkg::K_INIT:     n_state = (w_n == '0) ? cspe_pkg::S_FIN
                                                                    : cspe_pkg::S_INIT;
                        cspe_pkg::K_ISECT,
                        cspe_pkg::K_EXCL,
                        cspe_pkg::K_EXCL_ONE,
                        cspe_pkg::K_QUERY:    n_state = cspe_pkg::S_POS;
                        cspe_pkg::K_MEMBER:   n_state = cspe_pkg::S_MEM;
                        default:              n_state = cspe_pkg::S_FIN;
                    endcase
                end
            end
            cspe_pkg::S_POS:  n_state = w_swap ? cspe_pkg::S_ELEM : cspe_pkg::S_FIN;
            cspe_pkg::S_ELEM: n_state = cspe_pkg::S_WR2;
            cspe_pkg::S_WR2:  n_state = cspe_pkg::S_FIN;
            cspe_pkg::S_MEM:  n_state = cspe_pkg::S_FIN;
            cspe_pkg::S_INIT: n_state = w_init_last ? cspe_pkg::S_FIN : cspe_pkg::S_INIT;
            cspe_pkg::S_FIN:  n_state = cspe_pkg::S_IDLE;
            default:          n_state = cspe_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs: busy and RAM port control
    always_comb begin
        busy       = (r_state != cspe_pkg::S_IDLE);
        pos_raddr  = AW'(i_element);
        elem_raddr = (r_state == cspe_pkg::S_POS) ? AW'(w_pa_sum) : AW'(w_mpos);
        elem_we    = 1'b0;
        elem_waddr = '0;
        elem_wdata = '0;
        pos_we     = 1'b0;
        pos_waddr  = '0;
        pos_wdata  = '0;
        case (r_state)
            cspe_pkg::S_ELEM: begin
                // element moves to the target slot
                elem_we    = 1'b1;
                elem_waddr = r_pa;
                elem_wdata = r_elem;
                pos_we     = 1'b1;
                pos_waddr  = AW'(r_elem);
                pos_wdata  = EW'(r_pa);
            end
            cspe_pkg::S_WR2: begin
                // displaced element takes the vacated slot
                elem_we    = 1'b1;
                elem_waddr = AW'(r_pb);
                elem_wdata = r_ea;
                pos_we     = 1'b1;
                pos_waddr  = AW'(r_ea);
                pos_wdata  = r_pb;
            end
            cspe_pkg::S_INIT: begin
                elem_we    = 1'b1;
                elem_waddr = AW'(r_idx);
                elem_wdata = EW'(r_idx);
                pos_we     = 1'b1;
                pos_waddr  = AW'(r_idx);
                pos_wdata  = EW'(r_idx);
            end
            default: begin
                elem_we = 1'b0;
                pos_we  = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= cspe_pkg::S_IDLE;
            r_active   <= cspe_pkg::ACTIVE_RST;
            r_ws       <= '0;
            r_wsz      <= '0;
            r_rc       <= '0;
            r_run_open <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == cspe_pkg::S_FIN);
            if (i_cfg_valid && o_cfg_ready) begin
                r_active <= i_cfg_data;
            end
            case (r_state)
                cspe_pkg::S_POS: begin
                    if ((r_kind == cspe_pkg::K_ISECT) || (r_kind == cspe_pkg::K_EXCL)) begin
                        r_run_open <= 1'b1;
                        if (!w_do) begin
                            r_rc <= w_rc0;
                        end else if (r_kind == cspe_pkg::K_ISECT) begin
                            r_rc <= w_rc0 + CW'(1);
                        end else begin
                            r_rc <= w_rc0 - CW'(1);
                        end
                    end else if ((r_kind == cspe_pkg::K_EXCL_ONE) && w_do) begin
                        r_wsz <= r_wsz - CW'(1);
                    end
                end
                cspe_pkg::S_FIN: begin
                    if (r_kind == cspe_pkg::K_INIT) begin
                        r_ws       <= '0;
                        r_wsz      <= w_n;
                        r_rc       <= '0;
                        r_run_open <= 1'b0;
                    end else if (r_kind == cspe_pkg::K_LOAD) begin
                        r_ws       <= w_ld_ws;
                        r_wsz      <= w_ld_wz;
                        r_rc       <= '0;
                        r_run_open <= 1'b0;
                    end else if (w_commit) begin
                        r_wsz      <= r_rc;
                        r_rc       <= '0;
                        r_run_open <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            cspe_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_kind    <= cspe_pkg::t_kind'(i_kind);
                    r_elem    <= i_element;
                    r_last    <= i_last_in_run;
                    r_ws_in   <= i_window_start_in;
                    r_wz_in   <= i_window_size_in;
                    r_eok     <= w_eok_in;
                    r_idx     <= '0;
                    r_mval    <= 1'b0;
                    r_mem_ok  <= 1'b0;
                    r_inside  <= 1'b0;
                    r_pos_out <= '0;
                    r_mem_out <= '0;
                    r_clip    <= 1'b0;
                    if (cspe_pkg::t_kind'(i_kind) == cspe_pkg::K_MEMBER) begin
                        r_mval   <= w_mval_in;
                        r_mem_ok <= w_mval_in && (int'(w_mpos) < cspe_pkg::MAX_VERTICES);
                    end
                end
            end
            cspe_pkg::S_POS: begin
                r_inside  <= w_inside;
                r_pb      <= pos_rdata;
                r_pa      <= AW'(w_pa_sum);
                r_pos_out <= r_eok ? pos_rdata : '0;
            end
            cspe_pkg::S_ELEM: begin
                r_ea <= elem_rdata;
            end
            cspe_pkg::S_WR2: begin
                r_pos_out <= EW'(r_pa);
            end
            cspe_pkg::S_MEM: begin
                r_mem_out <= r_mem_ok ? elem_rdata : '0;
            end
            cspe_pkg::S_INIT: begin
                r_idx <= r_idx + CW'(1);
            end
            cspe_pkg::S_FIN: begin
                r_out_rc  <= w_fin_rc;
                r_out_wsz <= w_fin_wsz;
                r_clip    <= (r_kind == cspe_pkg::K_LOAD) && w_ld_clip;
            end
            default: begin
            end
        endcase
    end

    assign o_cfg_ready       = 1'b1;
    assign o_strobe          = r_strobe;
    assign o_in_window       = r_inside;
    assign o_position        = r_pos_out;
    assign o_member_out      = r_mem_out;
    assign o_member_valid    = r_mval;
    assign o_run_count       = r_out_rc;
    assign o_window_size_out = r_out_wsz;
    assign o_clipped         = r_clip;

    // a taken request always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("request taken but sequencer stayed idle");

    // result strobe follows the finish cycle and the sequencer is free again
    a_strobe_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) == cspe_pkg::S_FIN) && !busy)
        else $error("result strobe outside finish sequence");

    // second swap write only directly after the first
    a_wr2_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cspe_pkg::S_WR2) |-> ($past(r_state) == cspe_pkg::S_ELEM))
        else $error("swap write-back out of order");

    // with no run open the running count is zero
    a_run_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_run_open |-> (r_rc == '0))
        else $error("running count nonzero with no open run");

    // table writes only in swap write-back or init sweep
    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (elem_we || pos_we) |-> ((r_state == cspe_pkg::S_ELEM) ||
                                 (r_state == cspe_pkg::S_WR2) ||
                                 (r_state == cspe_pkg::S_INIT)))
        else $error("table write in a non-writing state");

endmodule
